@@ rtl/svpwm_ip_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_pkg
// Shared types, constants and helper functions of the inverse park and
// space vector modulator.
// ----------------------------------------------------------------------------
package svpwm_ip_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] PERIOD_RST = 16'd4200;
    localparam logic [14:0] BUS_RST    = 15'd3072;
    localparam logic [14:0] QLIM_RST   = 15'd3072;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD  = 2'd0,
        REG_BUS_VOLTAGE = 2'd1,
        REG_Q_LIMIT     = 2'd2
    } cfg_reg_t;

    // quarter-wave sine polynomial coefficients
    localparam logic [15:0] SIN_A     = 16'd51472;
    localparam logic [14:0] SIN_B     = 15'd21167;
    localparam logic [11:0] SIN_C     = 12'd2463;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;

    localparam int SINE_LAT = 4;
    localparam int M1_W     = 43;
    localparam int NUM_W    = 36;
    localparam int T_W      = 38;

    typedef logic [2:0] sector_t;

    localparam sector_t SEC_ZERO = 3'd0;
    localparam sector_t SEC_1    = 3'd1;
    localparam sector_t SEC_2    = 3'd2;
    localparam sector_t SEC_3    = 3'd3;
    localparam sector_t SEC_4    = 3'd4;
    localparam sector_t SEC_5    = 3'd5;
    localparam sector_t SEC_6    = 3'd6;

    typedef struct packed {
        logic [M1_W-1:0] mag_x;
        logic [M1_W-1:0] mag_y;
        logic [M1_W-1:0] mag_z;
        logic            neg_x;
        logic            neg_y;
        logic            neg_z;
        sector_t         sector;
    } xyz_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // sign pattern {z>0, y>0, x>0} to sector
    function automatic sector_t sector_of(input logic [2:0] idx);
        sector_t s;
        case (idx)
            3'd3:    s = SEC_1;
            3'd1:    s = SEC_2;
            3'd5:    s = SEC_3;
            3'd4:    s = SEC_4;
            3'd6:    s = SEC_5;
            3'd2:    s = SEC_6;
            default: s = SEC_ZERO;
        endcase
        return s;
    endfunction

    // quadrant sign and mirrored quarter-wave argument
    function automatic logic [16:0] sine_arg(input logic [31:0] turn);
        logic [15:0] x;
        x = {1'b0, turn[29:15]};
        if (turn[30])
        begin
            x = 16'd32768 - x;
        end
        return {turn[31], x};
    endfunction

    function automatic logic signed [25:0] rnd_div256(input logic signed [33:0] v);
        logic [33:0] mag;
        logic [25:0] q;
        mag = v[33] ? 34'(-v) : 34'(v);
        q   = 26'((mag + 34'd128) >> 8);
        return v[33] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [25:0] rnd_div65536(input logic signed [43:0] v);
        logic [43:0] mag;
        logic [25:0] q;
        mag = v[43] ? 44'(-v) : 44'(v);
        q   = 26'((mag + 44'd32768) >> 16);
        return v[43] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [15:0] sat_duty(input logic signed [40:0] v,
                                             input logic [15:0] t);
        logic [15:0] r;
        if (v < 0)
        begin
            r = 16'd0;
        end
        else if (v > $signed({25'd0, t}))
        begin
            r = t;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/svpwm_ip_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_ifs
// Command, result and register write channels of the modulator.
// ----------------------------------------------------------------------------
interface svpwm_ip_cmd_if;
    logic               valid;
    logic               ready;
    logic [15:0]        electrical_angle;
    logic signed [15:0] q_voltage;
    logic signed [15:0] d_voltage;

    modport source (output valid, electrical_angle, q_voltage, d_voltage, input ready);
    modport sink   (input valid, electrical_angle, q_voltage, d_voltage, output ready);
endinterface

interface svpwm_ip_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector_number;

    modport source (output valid, duty_a, duty_b, duty_c, sector_number, input ready);
    modport sink   (input valid, duty_a, duty_b, duty_c, sector_number, output ready);
endinterface

interface svpwm_ip_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [15:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/svpwm_ip_sine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_sine
// Four stage quarter-wave polynomial sine in Q15.
// ----------------------------------------------------------------------------
module svpwm_ip_sine
    import svpwm_ip_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        x,
    input  logic               neg,
    output logic signed [16:0] s
);

    logic [15:0]        xa_reg, xb_reg, xc_reg;
    logic               na_reg, nb_reg, nc_reg;
    logic [15:0]        sqa_reg, sqb_reg;
    logic [14:0]        inner_reg;
    logic [15:0]        mid_reg;
    logic signed [16:0] s_reg;

    logic [14:0]        inner_next;
    logic [15:0]        mid_next;
    logic [16:0]        mag_next;
    logic [27:0]        p_c;
    logic [30:0]        p_i;
    logic [31:0]        p_m;

    always_comb
    begin
        p_c        = 28'(sqa_reg) * 28'(SIN_C);
        inner_next = 15'(16'(SIN_B) - 16'(p_c >> 15));
        p_i        = 31'(sqb_reg) * 31'(inner_reg);
        mid_next   = SIN_A - 16'(p_i >> 15);
        p_m        = 32'(xc_reg) * 32'(mid_reg);
        mag_next   = 17'(p_m >> 15);
        if (mag_next > 17'd32768)
        begin
            mag_next = 17'd32768;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg    <= x;
            na_reg    <= neg;
            sqa_reg   <= 16'((32'(x) * 32'(x)) >> 15);
            xb_reg    <= xa_reg;
            nb_reg    <= na_reg;
            sqb_reg   <= sqa_reg;
            inner_reg <= inner_next;
            xc_reg    <= xb_reg;
            nc_reg    <= nb_reg;
            mid_reg   <= mid_next;
            s_reg     <= nc_reg ? -$signed(mag_next) : $signed(mag_next);
        end
    end

    assign s = s_reg;

endmodule

@@ rtl/svpwm_ip_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_front
// Clamp, sine and cosine, inverse park, phase terms and sector class.
// ----------------------------------------------------------------------------
module svpwm_ip_front
    import svpwm_ip_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        electrical_angle,
    input  logic signed [15:0] q_voltage,
    input  logic signed [15:0] d_voltage,
    input  logic [14:0]        q_limit,
    input  q_stat_t            q_stat,
    output logic               q_push,
    output xyz_item_t          q_item
);

    localparam int STAGES = SINE_LAT + 6;
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    logic [STAGES-1:0]  vld_reg;
    logic               en;

    logic [31:0]        turn_s, turn_c;
    logic signed [15:0] lim_s, q_clamp;

    logic signed [15:0] q1_reg, d1_reg;
    logic [16:0]        arg_s_reg, arg_c_reg;
    logic signed [15:0] qd_reg [SINE_LAT];
    logic signed [15:0] dd_reg [SINE_LAT];
    logic signed [16:0] sin_v, cos_v;

    logic signed [32:0] p_qs_reg, p_dc_reg, p_qc_reg, p_ds_reg;
    logic signed [25:0] ua_reg, ub_reg, ub2_reg;
    logic signed [43:0] ra_reg;

    logic signed [25:0] r_next;
    logic signed [26:0] xd_next, yd_next, zd_next;
    logic signed [26:0] xd_reg, yd_reg, zd_reg;
    sector_t            sec_reg;
    xyz_item_t          item_reg;

    assign en       = !vld_reg[STAGES-1] || !q_stat.full;
    assign in_ready = en;
    assign q_push   = vld_reg[STAGES-1] && !q_stat.full;
    assign q_item   = item_reg;

    assign turn_s  = (32'(electrical_angle) & ANGLE_MASK) << (32 - ANGLE_BITS);
    assign turn_c  = turn_s + 32'h4000_0000;
    assign lim_s   = $signed({1'b0, q_limit});
    assign q_clamp = (q_voltage > lim_s) ? lim_s :
                     (q_voltage < -lim_s) ? -lim_s : q_voltage;

    svpwm_ip_sine u_sin
    (
        .clk (clk),
        .en  (en),
        .x   (arg_s_reg[15:0]),
        .neg (arg_s_reg[16]),
        .s   (sin_v)
    );

    svpwm_ip_sine u_cos
    (
        .clk (clk),
        .en  (en),
        .x   (arg_c_reg[15:0]),
        .neg (arg_c_reg[16]),
        .s   (cos_v)
    );

    always_comb
    begin
        r_next  = rnd_div65536(ra_reg);
        xd_next = 27'(ub2_reg) <<< 1;
        yd_next = 27'(r_next) - 27'(ub2_reg);
        zd_next = -27'(r_next) - 27'(ub2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg    <= q_clamp;
            d1_reg    <= d_voltage;
            arg_s_reg <= sine_arg(turn_s);
            arg_c_reg <= sine_arg(turn_c);
            qd_reg[0] <= q1_reg;
            dd_reg[0] <= d1_reg;
            for (int i = 1; i < SINE_LAT; i++)
            begin
                qd_reg[i] <= qd_reg[i-1];
                dd_reg[i] <= dd_reg[i-1];
            end
            p_qs_reg <= 33'(qd_reg[SINE_LAT-1] * sin_v);
            p_dc_reg <= 33'(dd_reg[SINE_LAT-1] * cos_v);
            p_qc_reg <= 33'(qd_reg[SINE_LAT-1] * cos_v);
            p_ds_reg <= 33'(dd_reg[SINE_LAT-1] * sin_v);
            ua_reg   <= rnd_div256(34'(p_dc_reg) - 34'(p_qs_reg));
            ub_reg   <= rnd_div256(34'(p_qc_reg) + 34'(p_ds_reg));
            ra_reg   <= 44'(ua_reg * $signed({1'b0, SQRT3_Q16}));
            ub2_reg  <= ub_reg;
            xd_reg   <= xd_next;
            yd_reg   <= yd_next;
            zd_reg   <= zd_next;
            sec_reg  <= sector_of({zd_next > 0, yd_next > 0, xd_next > 0});
            item_reg.mag_x  <= 43'(xd_reg[26] ? -xd_reg : xd_reg) * 43'(SQRT3_Q16);
            item_reg.mag_y  <= 43'(yd_reg[26] ? -yd_reg : yd_reg) * 43'(SQRT3_Q16);
            item_reg.mag_z  <= 43'(zd_reg[26] ? -zd_reg : zd_reg) * 43'(SQRT3_Q16);
            item_reg.neg_x  <= xd_reg[26];
            item_reg.neg_y  <= yd_reg[26];
            item_reg.neg_z  <= zd_reg[26];
            item_reg.sector <= sec_reg;
        end
    end

endmodule

@@ rtl/svpwm_ip_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_queue
// Small first-in first-out queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module svpwm_ip_queue
    import svpwm_ip_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  xyz_item_t push_item,
    input  logic      pop,
    output xyz_item_t head,
    output q_stat_t   stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    xyz_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/svpwm_ip_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_ip_back
// Period scaling, pipelined rounding division by bus voltage, duty
// placement per sector and the result register.
// ----------------------------------------------------------------------------
module svpwm_ip_back
    import svpwm_ip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_stat_t     q_stat,
    input  xyz_item_t   q_head,
    output logic        q_pop,
    input  logic [15:0] pwm_period,
    input  logic [14:0] bus_voltage,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] duty_a,
    output logic [15:0] duty_b,
    output logic [15:0] duty_c,
    output sector_t     sector_number
);

    localparam int LAST = NUM_W + 2;

    typedef struct packed {
        logic    neg_x;
        logic    neg_y;
        logic    neg_z;
        sector_t sector;
    } side_t;

    logic                en;
    logic [14:0]         vb_eff;
    logic [LAST:0]       vld_reg;
    side_t               side_reg [LAST+1];
    logic [58:0]         m2_reg   [3];
    logic [NUM_W-1:0]    work_reg [3][NUM_W+1];
    logic [14:0]         rem_reg  [3][NUM_W+1];
    logic [NUM_W-1:0]    work_next [3][NUM_W];
    logic [14:0]         rem_next  [3][NUM_W];
    logic [M1_W-1:0]     mag_in   [3];

    logic signed [T_W-1:0] tv [3];
    logic signed [T_W-1:0] t1_next, t2_next, t1_reg, t2_reg;
    logic signed [39:0]    base_next, lo_reg;
    logic signed [40:0]    lo_w, mid_w, hi_w;
    logic [15:0]           lo_s, mid_s, hi_s;

    logic                  out_vld_reg;
    logic [15:0]           da_reg, db_reg, dc_reg;
    sector_t               sec_reg;

    assign en     = !out_vld_reg || out_ready;
    assign q_pop  = en && !q_stat.empty;
    assign vb_eff = (bus_voltage == '0) ? 15'd1 : bus_voltage;

    assign mag_in[0] = q_head.mag_x;
    assign mag_in[1] = q_head.mag_y;
    assign mag_in[2] = q_head.mag_z;

    // one quotient bit per stage
    always_comb
    begin
        logic [15:0] trial;
        logic        fits;
        for (int l = 0; l < 3; l++)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                trial = {rem_reg[l][k], work_reg[l][k][NUM_W-1]};
                fits  = trial >= {1'b0, vb_eff};
                rem_next[l][k]  = fits ? 15'(trial - {1'b0, vb_eff}) : trial[14:0];
                work_next[l][k] = {work_reg[l][k][NUM_W-2:0], fits};
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            tv[l] = T_W'(work_reg[l][NUM_W]);
        end
        if (side_reg[LAST-1].neg_x)
        begin
            tv[0] = -tv[0];
        end
        if (side_reg[LAST-1].neg_y)
        begin
            tv[1] = -tv[1];
        end
        if (side_reg[LAST-1].neg_z)
        begin
            tv[2] = -tv[2];
        end
        case (side_reg[LAST-1].sector)
            SEC_1:
            begin
                t1_next = tv[1];
                t2_next = tv[0];
            end
            SEC_2:
            begin
                t1_next = -tv[1];
                t2_next = -tv[2];
            end
            SEC_3:
            begin
                t1_next = tv[0];
                t2_next = tv[2];
            end
            SEC_4:
            begin
                t1_next = -tv[0];
                t2_next = -tv[1];
            end
            SEC_5:
            begin
                t1_next = tv[2];
                t2_next = tv[1];
            end
            SEC_6:
            begin
                t1_next = -tv[2];
                t2_next = -tv[0];
            end
            default:
            begin
                t1_next = '0;
                t2_next = '0;
            end
        endcase
        base_next = $signed({24'd0, pwm_period}) - 40'(t1_next) - 40'(t2_next);
    end

    always_comb
    begin
        lo_w  = 41'(lo_reg);
        mid_w = lo_w + 41'(t1_reg);
        hi_w  = mid_w + 41'(t2_reg);
        lo_s  = sat_duty(lo_w, pwm_period);
        mid_s = sat_duty(mid_w, pwm_period);
        hi_s  = sat_duty(hi_w, pwm_period);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[LAST-1:0], !q_stat.empty};
            out_vld_reg <= vld_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= {q_head.neg_x, q_head.neg_y, q_head.neg_z, q_head.sector};
            for (int i = 1; i <= LAST; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int l = 0; l < 3; l++)
            begin
                m2_reg[l]      <= 59'(mag_in[l]) * 59'(pwm_period);
                work_reg[l][0] <= NUM_W'((m2_reg[l] + (59'(vb_eff) << 23)) >> 24);
                rem_reg[l][0]  <= '0;
                for (int k = 0; k < NUM_W; k++)
                begin
                    work_reg[l][k+1] <= work_next[l][k];
                    rem_reg[l][k+1]  <= rem_next[l][k];
                end
            end
            t1_reg  <= t1_next;
            t2_reg  <= t2_next;
            lo_reg  <= base_next >>> 1;
            sec_reg <= side_reg[LAST].sector;
            case (side_reg[LAST].sector)
                SEC_1:
                begin
                    da_reg <= lo_s;
                    db_reg <= mid_s;
                    dc_reg <= hi_s;
                end
                SEC_2:
                begin
                    db_reg <= lo_s;
                    da_reg <= mid_s;
                    dc_reg <= hi_s;
                end
                SEC_3:
                begin
                    db_reg <= lo_s;
                    dc_reg <= mid_s;
                    da_reg <= hi_s;
                end
                SEC_4:
                begin
                    dc_reg <= lo_s;
                    db_reg <= mid_s;
                    da_reg <= hi_s;
                end
                SEC_5:
                begin
                    dc_reg <= lo_s;
                    da_reg <= mid_s;
                    db_reg <= hi_s;
                end
                SEC_6:
                begin
                    da_reg <= lo_s;
                    dc_reg <= mid_s;
                    db_reg <= hi_s;
                end
                default:
                begin
                    da_reg <= lo_s;
                    db_reg <= lo_s;
                    dc_reg <= lo_s;
                end
            endcase
        end
    end

    assign out_valid     = out_vld_reg;
    assign duty_a        = da_reg;
    assign duty_b        = db_reg;
    assign duty_c        = dc_reg;
    assign sector_number = sec_reg;

endmodule

@@ rtl/svpwm_inverse_park_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_inverse_park_top
// Inverse park transform and space vector modulator with register port.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle unless a full queue holds the front,
// and each produces one result of three centred compare values and a sector.
// A command passes through sine, rotation and phase terms, the queue, and the
// back end, which is mostly the 36-stage pipelined division by the bus
// voltage. A four-entry queue lets the front keep taking commands while the
// result side is held. No clearing pass after reset; registers may be written
// whenever the block is idle.
module svpwm_inverse_park_top
    import svpwm_ip_pkg::*;
#(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input logic             clk,
    input logic             rst_n,
    svpwm_ip_cmd_if.sink    cmd,
    svpwm_ip_res_if.source  res,
    svpwm_ip_cfg_if.sink    cfg
);

    logic [15:0] period_reg;
    logic [14:0] bus_reg;
    logic [14:0] qlim_reg;

    logic        q_push;
    logic        q_pop;
    xyz_item_t   push_item;
    xyz_item_t   head_item;
    q_stat_t     q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            bus_reg    <= BUS_RST;
            qlim_reg   <= QLIM_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.reg_index))
                REG_PWM_PERIOD:  period_reg <= cfg.wdata;
                REG_BUS_VOLTAGE: bus_reg    <= cfg.wdata[14:0];
                REG_Q_LIMIT:     qlim_reg   <= cfg.wdata[14:0];
                default:         ;
            endcase
        end
    end

    svpwm_ip_front #(.ANGLE_BITS(ANGLE_BITS)) u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (cmd.valid),
        .in_ready         (cmd.ready),
        .electrical_angle (cmd.electrical_angle),
        .q_voltage        (cmd.q_voltage),
        .d_voltage        (cmd.d_voltage),
        .q_limit          (qlim_reg),
        .q_stat           (q_stat),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    svpwm_ip_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (head_item),
        .stat      (q_stat)
    );

    svpwm_ip_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_head        (head_item),
        .q_pop         (q_pop),
        .pwm_period    (period_reg),
        .bus_voltage   (bus_reg),
        .out_valid     (res.valid),
        .out_ready     (res.ready),
        .duty_a        (res.duty_a),
        .duty_b        (res.duty_b),
        .duty_c        (res.duty_c),
        .sector_number (res.sector_number)
    );

`ifndef NO_ASSERTIONS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_zero_vector_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.sector_number == SEC_ZERO) |->
        (res.duty_a == res.duty_b && res.duty_b == res.duty_c))
        else $error("zero vector duties differ");

    a_period_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready && cfg.reg_index == REG_PWM_PERIOD) |=>
        (period_reg == $past(cfg.wdata)))
        else $error("period register not updated");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the inverse park transform and space vector
// modulator. Commands are streamed over the command channel with random
// gaps, results are compared against a bit-exact predictor, and the
// registers are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import svpwm_ip_pkg::*;

    typedef struct {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic [2:0]  sector_number;
    } duty_set_t;

    localparam int LATENCY_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    svpwm_ip_cmd_if cmd_if ();
    svpwm_ip_res_if res_if ();
    svpwm_ip_cfg_if cfg_if ();

    svpwm_inverse_park_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if.sink),
        .res   (res_if.source),
        .cfg   (cfg_if.sink)
    );

    always #5 clk = ~clk;

    logic [15:0] period_q;
    logic [14:0] bus_q;
    logic [14:0] qlim_q;

    duty_set_t expected_duties[$];
    int  error_count = 0;
    int  result_count = 0;
    int  command_count = 0;
    longint cycle_count = 0;
    bit  hold_res = 1'b0;
    int  hold_cycles = 0;
    int  sector_seen[7];

    initial
    begin
        cmd_if.valid = 1'b0;
        cmd_if.electrical_angle = '0;
        cmd_if.q_voltage = '0;
        cmd_if.d_voltage = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.reg_index = '0;
        cfg_if.wdata = '0;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        if ((mag % den) * 2 >= den)
            q++;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint floor_half(longint v);
        if (v >= 0)
            return v / 2;
        return -((-v + 1) / 2);
    endfunction

    function automatic longint quarter_sine(logic [31:0] turn);
        longint x;
        longint x2;
        longint inner;
        longint mid;
        longint s;
        x = longint'(turn[29:15]);
        if (turn[30])
            x = 32768 - x;
        x2 = (x * x) >>> 15;
        inner = 21167 - ((x2 * 2463) >>> 15);
        mid = 51472 - ((x2 * inner) >>> 15);
        s = (x * mid) >>> 15;
        if (s > 32768)
            s = 32768;
        return turn[31] ? -s : s;
    endfunction

    function automatic logic [15:0] clip_duty(longint v, longint t);
        if (v < 0)
            return 16'd0;
        if (v > t)
            return t[15:0];
        return v[15:0];
    endfunction

    function automatic duty_set_t predict_duties(logic [15:0] angle, logic signed [15:0] qv,
                                                 logic signed [15:0] dv);
        duty_set_t r;
        logic [31:0] turn;
        longint q, d, lim, st, ct, ua, ub, rr, xd, yd, zd, tp, den, x, y, z;
        longint t1, t2, d1, d2, d3;
        int idx;
        logic [2:0] sec;
        turn = {angle, 16'd0};
        q = qv;
        d = dv;
        lim = qlim_q;
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        st = quarter_sine(turn);
        ct = quarter_sine(turn + 32'h4000_0000);
        ua = round_div(-q * st + d * ct, 256);
        ub = round_div(q * ct + d * st, 256);
        rr = round_div(ua * 113512, 65536);
        xd = 2 * ub;
        yd = rr - ub;
        zd = -rr - ub;
        tp = period_q;
        den = 64'd16777216 * ((bus_q == 0) ? 1 : bus_q);
        x = round_div(xd * 113512 * tp, den);
        y = round_div(yd * 113512 * tp, den);
        z = round_div(zd * 113512 * tp, den);
        idx = (xd > 0) + 2 * (yd > 0) + 4 * (zd > 0);
        case (idx)
            3: sec = SEC_1;
            1: sec = SEC_2;
            5: sec = SEC_3;
            4: sec = SEC_4;
            6: sec = SEC_5;
            2: sec = SEC_6;
            default: sec = SEC_ZERO;
        endcase
        case (sec)
            SEC_1:
            begin
                t1 = y; t2 = x;
                d1 = floor_half(tp - t1 - t2); d2 = d1 + t1; d3 = d2 + t2;
            end
            SEC_2:
            begin
                t1 = -y; t2 = -z;
                d2 = floor_half(tp - t1 - t2); d1 = d2 + t1; d3 = d1 + t2;
            end
            SEC_3:
            begin
                t1 = x; t2 = z;
                d2 = floor_half(tp - t1 - t2); d3 = d2 + t1; d1 = d3 + t2;
            end
            SEC_4:
            begin
                t1 = -x; t2 = -y;
                d3 = floor_half(tp - t1 - t2); d2 = d3 + t1; d1 = d2 + t2;
            end
            SEC_5:
            begin
                t1 = z; t2 = y;
                d3 = floor_half(tp - t1 - t2); d1 = d3 + t1; d2 = d1 + t2;
            end
            SEC_6:
            begin
                t1 = -z; t2 = -x;
                d1 = floor_half(tp - t1 - t2); d3 = d1 + t1; d2 = d3 + t2;
            end
            default:
            begin
                d1 = tp / 2; d2 = d1; d3 = d1;
            end
        endcase
        r.duty_a = clip_duty(d1, tp);
        r.duty_b = clip_duty(d2, tp);
        r.duty_c = clip_duty(d3, tp);
        r.sector_number = sec;
        return r;
    endfunction

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_command(logic [15:0] angle, logic signed [15:0] qv,
                                logic signed [15:0] dv, bit with_gap);
        int gap;
        gap = with_gap ? random_gap() : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.electrical_angle <= angle;
        cmd_if.q_voltage <= qv;
        cmd_if.d_voltage <= dv;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        expected_duties.push_back(predict_duties(angle, qv, dv));
        command_count++;
    endtask

    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (expected_duties.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [15:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_PWM_PERIOD:  period_q = value;
            REG_BUS_VOLTAGE: bus_q = value[14:0];
            REG_Q_LIMIT:     qlim_q = value[14:0];
            default: ;
        endcase
    endtask

    task automatic program_all(logic [15:0] t, logic [14:0] vb, logic [14:0] ql);
        drain_results();
        write_register(REG_PWM_PERIOD, t);
        write_register(REG_BUS_VOLTAGE, {1'b0, vb});
        write_register(REG_Q_LIMIT, {1'b0, ql});
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_random(int n, bit wide);
        logic signed [15:0] qv;
        logic signed [15:0] dv;
        for (int i = 0; i < n; i++)
        begin
            if (wide || $urandom_range(0, 3) == 0)
            begin
                qv = 16'($urandom);
                dv = 16'($urandom);
            end
            else
            begin
                qv = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
                dv = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            end
            send_command(16'($urandom), qv, dv, 1'b1);
        end
    endtask

    task automatic test_directed_extremes();
        logic [15:0] angles[8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                   16'h2AAB, 16'h5555, 16'hFFFF, 16'h1555};
        foreach (angles[i])
            send_command(angles[i], 16'sd1500, 16'sd300, 1'b0);
        send_command(16'h1234, 16'sd0, 16'sd0, 1'b0);
        send_command(16'h7000, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_command(16'h9000, -16'sd32768, -16'sd32768, 1'b0);
        send_command(16'hE000, -16'sd32768, 16'sh7FFF, 1'b0);
        send_command(16'h0800, 16'sd5000, -16'sd2, 1'b0);
        send_command(16'hAAAA, 16'sd1, -16'sd1, 1'b0);
    endtask

    task automatic test_register_extremes();
        program_all(16'd65535, 15'd1, 15'd32767);
        send_random(8, 1'b1);
        program_all(16'd1, 15'd32767, 15'd0);
        send_random(8, 1'b1);
        program_all(16'd0, 15'd0, 15'd100);
        send_random(5, 1'b1);
        program_all(16'd4200, 15'd3072, 15'd3072);
    endtask

    task automatic test_random_stream();
        send_random(300, 1'b0);
        program_all(16'($urandom_range(1000, 20000)), 15'($urandom_range(500, 8000)),
                    15'($urandom_range(0, 32767)));
        send_random(200, 1'b0);
    endtask

    task automatic test_backpressure();
        program_all(16'd8000, 15'd4000, 15'd20000);
        hold_cycles = 300;
        hold_res = 1'b1;
        send_random(100, 1'b0);
        drain_results();
        send_random(60, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (hold_res)
        begin
            res_if.ready <= 1'b0;
            if (hold_cycles > 0)
                hold_cycles <= hold_cycles - 1;
            else
                hold_res <= 1'b0;
        end
        else if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(0, 99) < 70) || (cycle_count[9:7] == 3'd0);
    end

    always @(posedge clk)
    begin
        duty_set_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            result_count++;
            if (expected_duties.size() == 0)
            begin
                $error("result with nothing outstanding");
                error_count++;
            end
            else
            begin
                e = expected_duties.pop_front();
                sector_seen[res_if.sector_number % 7]++;
                if (res_if.duty_a !== e.duty_a)
                begin
                    $error("duty_a expected %0d got %0d", e.duty_a, res_if.duty_a);
                    error_count++;
                end
                if (res_if.duty_b !== e.duty_b)
                begin
                    $error("duty_b expected %0d got %0d", e.duty_b, res_if.duty_b);
                    error_count++;
                end
                if (res_if.duty_c !== e.duty_c)
                begin
                    $error("duty_c expected %0d got %0d", e.duty_c, res_if.duty_c);
                    error_count++;
                end
                if (res_if.sector_number !== e.sector_number)
                begin
                    $error("sector_number expected %0d got %0d", e.sector_number,
                           res_if.sector_number);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        period_q = PERIOD_RST;
        bus_q = BUS_RST;
        qlim_q = QLIM_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_register_extremes();
        test_random_stream();
        test_backpressure();
        drain_results();
        if (expected_duties.size() != 0)
        begin
            $error("%0d results never arrived", expected_duties.size());
            error_count++;
        end
        $display("%0d transactions sent, %0d results checked, sectors 0..6 seen: %0d %0d %0d %0d %0d %0d %0d",
                 command_count, result_count, sector_seen[0], sector_seen[1], sector_seen[2],
                 sector_seen[3], sector_seen[4], sector_seen[5], sector_seen[6]);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ files.f @@
rtl/svpwm_ip_pkg.sv
rtl/svpwm_ip_ifs.sv
rtl/svpwm_ip_sine.sv
rtl/svpwm_ip_front.sv
rtl/svpwm_ip_queue.sv
rtl/svpwm_ip_back.sv
rtl/svpwm_inverse_park_top.sv
dv/tb_top.sv
